FILE: src/fdcp_pkg.sv
`timescale 1ns / 1ps

package fdcp_pkg;

  localparam logic [7:0] SlashByte = 8'h2F;  // '/'
  localparam logic [7:0] StarByte  = 8'h2A;  // '*'
  localparam logic [7:0] PlusByte  = 8'h2B;  // '+'
  localparam logic [7:0] MinusByte = 8'h2D;  // '-'

  localparam logic [31:0] PosLimit = 32'h7FFF_FFFF;
  localparam logic [31:0] NegLimit = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic               saturated;
  } result_t;

endpackage

FILE: src/fdcp_parse.sv
`timescale 1ns / 1ps

module fdcp_parse #(
  parameter int BUFFER_LEN = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  output fdcp_pkg::result_t result_o
);
  import fdcp_pkg::*;

  localparam int CntW = (BUFFER_LEN > 2) ? $clog2(BUFFER_LEN) : 1;
  localparam logic [CntW-1:0] StoreMax = CntW'(BUFFER_LEN - 1);

  logic [CntW-1:0] count_q, count_d;
  phase_e          phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [31:0]     mag_q, mag_d;
  logic            ovf_q, ovf_d;

  logic        is_space, is_digit, is_sign;
  logic [35:0] mag_next;
  logic [35:0] limit;
  logic [31:0] dig_mag;
  logic        dig_ovf;

  assign is_space = byte_i inside {[8'd9:8'd13], 8'd32};
  assign is_digit = byte_i inside {[8'h30:8'h39]};
  assign is_sign  = (byte_i == PlusByte) || (byte_i == MinusByte);

  // mag * 10 + digit, as shift-and-add
  assign mag_next = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {32'b0, byte_i[3:0]};

  always_comb begin
    limit   = {4'b0, (neg_q ? NegLimit : PosLimit)};
    dig_ovf = mag_next > limit;
    dig_mag = dig_ovf ? limit[31:0] : mag_next[31:0];
  end

  always_comb begin
    count_d = count_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    ovf_d   = ovf_q;
    if (take_i) begin
      if (byte_i == SlashByte) begin
        count_d = '0;
        phase_d = PH_SKIP;
        neg_d   = 1'b0;
        mag_d   = '0;
        ovf_d   = 1'b0;
      end else if (byte_i != StarByte && count_q < StoreMax) begin
        count_d = count_q + 1'b1;
        case (phase_q)
          PH_SKIP: begin
            if (is_space) begin
              phase_d = PH_SKIP;
            end else if (is_sign) begin
              neg_d   = (byte_i == MinusByte);
              phase_d = PH_SIGN;
            end else if (is_digit) begin
              mag_d   = dig_mag;
              ovf_d   = ovf_q | dig_ovf;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_DONE;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (is_digit) begin
              mag_d   = dig_mag;
              ovf_d   = ovf_q | dig_ovf;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      ovf_q   <= ovf_d;
    end
  end

  assign result_o.value     = neg_q ? -$signed(mag_q) : $signed(mag_q);
  assign result_o.saturated = ovf_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= StoreMax) else $error("store count beyond limit");

  a_mag_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mag_q <= PosLimit) || (neg_q && mag_q == NegLimit)) else $error("magnitude out of range");

  a_ovf_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (phase_q == PH_DIGITS || phase_q == PH_DONE)) else $error("overflow without digits");

  a_slash_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && byte_i == SlashByte) |=> (count_q == '0 && phase_q == PH_SKIP && !ovf_q))
    else $error("clear not applied");

endmodule

FILE: src/fdcp_out_reg.sv
`timescale 1ns / 1ps

module fdcp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fdcp_pkg::result_t data_i,
  input  logic              ready_i,
  output logic              valid_o,
  output fdcp_pkg::result_t data_o
);
  import fdcp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign valid_d = load_i | (valid_q & ~ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // a load may only land in an empty slot or one being drained
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || ready_i)) else $error("result overwritten");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (valid_q && data_q == $past(data_i))) else $error("loaded result lost");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ready_i && !load_i) |=> !valid_q) else $error("result repeated");

endmodule

FILE: src/framed_decimal_command_parser_unit.sv
`timescale 1ns / 1ps

// Framed decimal command parser.
// Input channel: one received byte per transfer (rx_byte_i, in_valid_i/in_ready_o).
// '/' clears the message, '*' requests a result, any other byte is stored
// (up to BUFFER_LEN-1 bytes) and parsed on the fly as C atoi would:
// whitespace, optional sign, decimal digits, stop at anything else.
// Output channel: value_o / saturated_o with out_valid_o/out_ready_i; one
// result per '*', the value saturated to 32 bits and saturated_o set if so.
// Throughput: one byte per cycle. The parse state is updated in the cycle
// the byte is taken; the multiply-by-ten and add sit between the state
// registers. A '*' shows its result in the cycle after its transfer, from the
// output register.
// When the receiver stalls, ordinary bytes are still taken; only a '*'
// waits (in_ready_o low) while an untaken result occupies the register.
// Reset clears the message and empties the output register.

module framed_decimal_command_parser_unit #(
  parameter int BUFFER_LEN = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               saturated_o
);
  import fdcp_pkg::*;

  logic    take;
  logic    is_star;
  result_t cur_res;
  result_t out_res;

  assign is_star    = (rx_byte_i == StarByte);
  assign in_ready_o = !is_star || !out_valid_o || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  fdcp_parse #(
    .BUFFER_LEN(BUFFER_LEN)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (rx_byte_i),
    .result_o(cur_res)
  );

  fdcp_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take && is_star),
    .data_i (cur_res),
    .ready_i(out_ready_i),
    .valid_o(out_valid_o),
    .data_o (out_res)
  );

  assign value_o     = out_res.value;
  assign saturated_o = out_res.saturated;

endmodule

FILE: dv/framed_decimal_command_parser_unit_tb.sv
`timescale 1ns / 1ps

module framed_decimal_command_parser_unit_tb;
  import fdcp_pkg::*;

  localparam int BufLen = 50;
  localparam int HoldCycles = 400;
  localparam int StuckLimit = 4000;
  localparam int PhaseBytes = 300;

  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [7:0] TabChar   = 8'h09;
  localparam logic [7:0] CrChar    = 8'h0D;
  localparam logic [7:0] SpaceChar = 8'h20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] value;
  logic               saturated;

  // stimulus and expectations
  logic [7:0] byte_queue[$];
  result_t    pending_results[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         fault_count = 0;
  int         stuck_cycles = 0;

  // receiver hold-off request: toggled by the sequence, acknowledged by the receiver
  logic       hold_kick = 1'b0;
  logic       hold_ack = 1'b0;
  int         hold_left = 0;

  // parser state as predicted
  int          msg_len;
  phase_e      phase;
  logic        neg_sign;
  logic [31:0] mag_acc;
  logic        clamped;

  framed_decimal_command_parser_unit #(
    .BUFFER_LEN(BufLen)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .rx_byte_i  (rx_byte),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .value_o    (value),
    .saturated_o(saturated)
  );

  always #4 clk = ~clk;

  task automatic clear_message();
    msg_len  = 0;
    phase    = PH_SKIP;
    neg_sign = 1'b0;
    mag_acc  = '0;
    clamped  = 1'b0;
  endtask

  task automatic take_digit(input logic [7:0] b);
    logic [63:0] acc;
    logic [63:0] lim;
    lim = neg_sign ? 64'd2147483648 : 64'd2147483647;
    acc = {32'd0, mag_acc} * 64'd10 + 64'(b - ZeroChar);
    if (acc > lim) begin
      acc = lim;
      clamped = 1'b1;
    end
    mag_acc = acc[31:0];
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    result_t res;
    logic    is_ws;
    logic    is_dig;
    is_ws  = (b >= TabChar && b <= CrChar) || b == SpaceChar;
    is_dig = b >= ZeroChar && b <= ZeroChar + 8'd9;
    if (b == SlashByte) begin
      clear_message();
    end else if (b == StarByte) begin
      res.value     = neg_sign ? -mag_acc : mag_acc;
      res.saturated = clamped;
      pending_results.push_back(res);
    end else if (msg_len < BufLen - 1) begin
      msg_len++;
      case (phase)
        PH_SKIP: begin
          if (is_ws) begin
          end else if (b == PlusByte || b == MinusByte) begin
            neg_sign = (b == MinusByte);
            phase = PH_SIGN;
          end else if (is_dig) begin
            take_digit(b);
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_dig) begin
            take_digit(b);
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte  <= '0;
    end else if (!in_valid || in_ready) begin
      if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        rx_byte  <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_kick != hold_ack) begin
      hold_ack  <= hold_kick;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: output transfer is checked before the input transfer of the same edge
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_message();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: value %0d saturated %0b", value, saturated);
          fault_count++;
        end else begin
          want = pending_results.pop_front();
          if (want.value !== value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            fault_count++;
          end
          if (want.saturated !== saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, saturated);
            fault_count++;
          end
        end
      end
      if (in_valid && in_ready) parse_rx_byte(rx_byte);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    byte_queue.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_space();
    int n;
    n = $urandom_range(6);
    return (n < 5) ? 8'(TabChar + n) : SpaceChar;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(ZeroChar + $urandom_range(9));
  endfunction

  // mostly framed numbers with random content; some noise and broken frames
  task automatic queue_message();
    int    pick;
    int    n;
    string bound;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
      return;
    end
    if (pick >= 12) add_byte(SlashByte);
    repeat ($urandom_range(0, 2)) add_byte(pick_space());
    // long runs of whitespace can fill the store so later digits are dropped
    if ($urandom_range(99) < 4) repeat ($urandom_range(40, 55)) add_byte(pick_space());
    case ($urandom_range(5))
      0: add_byte(PlusByte);
      1, 2: add_byte(MinusByte);
      3: begin
        add_byte($urandom_range(1) ? MinusByte : PlusByte);
        add_byte($urandom_range(1) ? MinusByte : PlusByte);
      end
      default: ;
    endcase
    n = $urandom_range(99);
    if (n < 10) begin
      case ($urandom_range(2))
        0: bound = "2147483647";
        1: bound = "2147483648";
        default: bound = "2147483649";
      endcase
      add_text(bound);
    end else if (n < 25) begin
      repeat ($urandom_range(10, 14)) add_byte(pick_digit());
    end else if (n >= 30) begin
      repeat ($urandom_range(1, 9)) add_byte(pick_digit());
    end
    if ($urandom_range(99) < 20) begin
      add_byte(8'($urandom_range(255)));
      repeat ($urandom_range(0, 2)) add_byte(pick_digit());
    end
    if ($urandom_range(99) < 95) add_byte(StarByte);
    if ($urandom_range(99) < 10) add_byte(StarByte);
  endtask

  task automatic drain();
    while (byte_queue.size() > 0 || in_valid || pending_results.size() > 0) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input logic hold);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_kick = ~hold_kick;
    while (byte_queue.size() < PhaseBytes) queue_message();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    add_text("/ -42*");
    add_text("/+-3*");
    add_text("/9");
    add_byte(8'h00);
    add_text("8*");
    add_byte(SlashByte);
    add_byte(8'hFF);
    add_text("5*");
    add_byte(SlashByte);
    add_byte(CrChar);
    add_text("+7**");
    drain();

    run_phase(0, 0, 1'b0);
    run_phase(78, 0, 1'b0);
    run_phase(0, 78, 1'b0);
    run_phase(35, 35, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (6) @(negedge clk);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/fdcp_pkg.sv
src/fdcp_parse.sv
src/fdcp_out_reg.sv
src/framed_decimal_command_parser_unit.sv
dv/framed_decimal_command_parser_unit_tb.sv
